[hdl/srcm_pkg.sv]
// Package for the sensor range calibrate-and-map block.
// Holds widths, register indexes, the queue entry and status types and the back-end state type.
// No dependencies.
package srcm_pkg;

   // Converter sample width
   localparam int SAMPLE_BITS = 10;
   // Fixed field widths
   localparam int CNT_BITS    = 10;
   localparam int PWM_BITS    = 16;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;

   // Product of a sample offset and the output span, and the divider step counter
   localparam int PROD_BITS   = SAMPLE_BITS + PWM_BITS;
   localparam int STEP_BITS   = $clog2(PROD_BITS);

   // Queue between the front and back ends
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Register reset values
   localparam logic [CNT_BITS-1:0] CAL_SAMPLES_RST = CNT_BITS'(999);
   localparam logic [PWM_BITS-1:0] OUT_LOW_RST     = '0;
   localparam logic [PWM_BITS-1:0] OUT_HIGH_RST    = '1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_SAMPLES = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_LOW     = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_HIGH    = CSR_IDX_BITS'(2);

   // One classified item as it waits for the back end
   typedef struct packed {
      logic                   calibrating; // answer 0 with the flag set
      logic                   degenerate;  // empty or inverted sensor range
      logic [SAMPLE_BITS-1:0] offset;      // clamped sample minus range minimum
      logic [SAMPLE_BITS-1:0] span;        // range maximum minus range minimum
   } srcm_entry_type;

   // Queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } srcm_qstat_type;

   // Back-end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } srcm_state_type;

endpackage

[hdl/srcm_front.sv]
// Front end: accepts samples, tracks the calibration range and phase, classifies each item.
// Depends on srcm_pkg.
module srcm_front import srcm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   req_stall,
   input  logic [CNT_BITS-1:0]    cal_samples,
   input  srcm_qstat_type         qstat,
   output logic                   push,
   output srcm_entry_type         push_entry
);

   logic [CNT_BITS-1:0]    seen_count_ff, seen_count_in;
   logic                   mapping_ff, mapping_in;
   logic [SAMPLE_BITS-1:0] range_min_ff, range_min_in;
   logic [SAMPLE_BITS-1:0] range_max_ff, range_max_in;
   logic [CNT_BITS-1:0]    seen_next;
   logic [SAMPLE_BITS-1:0] clamped;

   // Accept whenever the queue has room
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   // Classify the item against the current range
   always_comb begin
      if (req_sample < range_min_ff) begin
         clamped = range_min_ff;
      end else if (req_sample > range_max_ff) begin
         clamped = range_max_ff;
      end else begin
         clamped = req_sample;
      end
      push_entry.calibrating = !mapping_ff;
      push_entry.degenerate  = (range_max_ff <= range_min_ff);
      push_entry.offset      = clamped - range_min_ff;
      push_entry.span        = range_max_ff - range_min_ff;
   end

   // Calibration state update, saturating sample count
   always_comb begin
      seen_next     = (seen_count_ff != '1) ? seen_count_ff + CNT_BITS'(1) : seen_count_ff;
      seen_count_in = seen_count_ff;
      mapping_in    = mapping_ff;
      range_min_in  = range_min_ff;
      range_max_in  = range_max_ff;
      if (push && !mapping_ff) begin
         seen_count_in = seen_next;
         mapping_in    = (seen_next >= cal_samples);
         if (req_sample > range_max_ff) begin
            range_max_in = req_sample;
         end
         if (req_sample < range_min_ff) begin
            range_min_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
         mapping_ff    <= 1'b0;
         range_min_ff  <= '1;
         range_max_ff  <= '0;
      end else begin
         seen_count_ff <= seen_count_in;
         mapping_ff    <= mapping_in;
         range_min_ff  <= range_min_in;
         range_max_ff  <= range_max_in;
      end
   end

endmodule

[hdl/srcm_queue.sv]
// Short queue of classified items between the front and back ends.
// Depends on srcm_pkg.
module srcm_queue import srcm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  srcm_entry_type push_entry,
   input  logic           pop,
   output srcm_entry_type pop_entry,
   output srcm_qstat_type qstat
);

   srcm_entry_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_entry   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/srcm_back.sv]
// Back end: multiplies the offset by the output span, divides by the sensor span one
// quotient bit a cycle, adds the lower limit and holds the result. Depends on srcm_pkg.
module srcm_back import srcm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  srcm_qstat_type      qstat,
   input  srcm_entry_type      pop_entry,
   output logic                pop,
   input  logic [PWM_BITS-1:0] out_low,
   input  logic [PWM_BITS-1:0] out_high,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PWM_BITS-1:0] rsp_pwm_value,
   output logic                rsp_calibrating
);

   srcm_state_type         state_ff, state_in;
   logic                   bypass;
   logic                   div_last;
   logic [SAMPLE_BITS-1:0] offset_ff, offset_in;
   logic [SAMPLE_BITS-1:0] span_ff, span_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SAMPLE_BITS:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [PWM_BITS-1:0]    result_ff, result_in;
   logic                   calib_ff, calib_in;
   logic [SAMPLE_BITS:0]   rem_shift;
   logic                   q_bit;
   logic [PWM_BITS-1:0]    span_out;

   // Items that need no division
   assign bypass   = pop_entry.calibrating || pop_entry.degenerate || (out_high < out_low);
   assign div_last = (step_ff == STEP_BITS'(PROD_BITS - 1));
   assign span_out = out_high - out_low;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               state_in = bypass ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      pop       = (state_ff == ST_IDLE) && !qstat.empty;
      rsp_valid = (state_ff == ST_OUT);
   end

   // Restoring divide step: remainder stays below the span
   always_comb begin
      rem_shift = {rem_ff[SAMPLE_BITS-1:0], prod_ff[PROD_BITS-1]};
      q_bit     = (rem_shift >= {1'b0, span_ff});
   end

   // Datapath
   always_comb begin
      offset_in = offset_ff;
      span_in   = span_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      result_in = result_ff;
      calib_in  = calib_ff;
      unique case (state_ff)
         ST_IDLE: begin
            offset_in = pop_entry.offset;
            span_in   = pop_entry.span;
            calib_in  = pop_entry.calibrating;
            result_in = pop_entry.calibrating ? '0 : out_low;
         end
         ST_MUL: begin
            prod_in = PROD_BITS'(offset_ff) * PROD_BITS'(span_out);
            rem_in  = '0;
            step_in = '0;
         end
         ST_DIV: begin
            rem_in  = q_bit ? (rem_shift - {1'b0, span_ff}) : rem_shift;
            prod_in = {prod_ff[PROD_BITS-2:0], q_bit};
            step_in = step_ff + STEP_BITS'(1);
         end
         ST_FIN: begin
            // quotient never exceeds the output span
            result_in = prod_ff[PWM_BITS-1:0] + out_low;
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      span_ff   <= span_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      result_ff <= result_in;
      calib_ff  <= calib_in;
   end

   assign rsp_pwm_value   = result_ff;
   assign rsp_calibrating = calib_ff;

endmodule

[hdl/sensor_range_calibrate_and_map_top.sv]
// Sensor range calibrate-and-map. The first cal_samples samples calibrate the sensor range
// (running minimum and maximum) and answer pwm_value 0 with calibrating set; later samples
// are clamped into that range and mapped linearly onto [out_low, out_high]. Timing: the
// front end takes one item per cycle into a two-entry queue while it has room, so it keeps
// accepting while the back end works. The back end handles one item at a time: a
// calibration item, or one with an empty sensor range or inverted limits, skips the
// multiply and divide; a mapped item goes through the 26-step restoring divider that
// produces one quotient bit per cycle. There is no clearing pass after reset.
// Depends on srcm_pkg, srcm_front, srcm_queue and srcm_back.
module sensor_range_calibrate_and_map_top import srcm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [PWM_BITS-1:0]     rsp_pwm_value,
   output logic                    rsp_calibrating,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wr_data
);

   logic [CNT_BITS-1:0] cal_samples_ff, cal_samples_in;
   logic [PWM_BITS-1:0] out_low_ff, out_low_in;
   logic [PWM_BITS-1:0] out_high_ff, out_high_in;
   srcm_qstat_type      qstat;
   srcm_entry_type      push_entry;
   srcm_entry_type      pop_entry;
   logic                push;
   logic                pop;

   // Configuration registers; unknown indexes are dropped
   always_comb begin
      cal_samples_in = cal_samples_ff;
      out_low_in     = out_low_ff;
      out_high_in    = out_high_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAL_SAMPLES: cal_samples_in = csr_wr_data[CNT_BITS-1:0];
            CSR_OUT_LOW:     out_low_in     = csr_wr_data[PWM_BITS-1:0];
            CSR_OUT_HIGH:    out_high_in    = csr_wr_data[PWM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff <= CAL_SAMPLES_RST;
         out_low_ff     <= OUT_LOW_RST;
         out_high_ff    <= OUT_HIGH_RST;
      end else begin
         cal_samples_ff <= cal_samples_in;
         out_low_ff     <= out_low_in;
         out_high_ff    <= out_high_in;
      end
   end

   srcm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_sample  (req_sample),
      .req_stall   (req_stall),
      .cal_samples (cal_samples_ff),
      .qstat       (qstat),
      .push        (push),
      .push_entry  (push_entry)
   );

   srcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   srcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .out_low         (out_low_ff),
      .out_high        (out_high_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pwm_value   (rsp_pwm_value),
      .rsp_calibrating (rsp_calibrating)
   );

endmodule

[hdl/srcm_checker.sv]
// Port-level checker for the sensor range calibrate-and-map top level, with its bind.
// Depends on srcm_pkg.
module srcm_checker import srcm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [PWM_BITS-1:0]    rsp_pwm_value,
   input logic                   rsp_calibrating
);

   logic mapped_ff, mapped_in;

   // Remember that a mapped item has been delivered since reset
   assign mapped_in = mapped_ff || (rsp_valid && !rsp_stall && !rsp_calibrating);

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= 1'b0;
      end else begin
         mapped_ff <= mapped_in;
      end
   end

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pwm_value)
                                 && $stable(rsp_calibrating))
      else $error("stalled result changed");

   // Calibration items always answer zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> rsp_pwm_value == '0)
      else $error("calibration item with nonzero duty value");

   // Once mapping, the block never returns to calibrating
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> !mapped_ff)
      else $error("calibration result after mapping began");

   // Out of reset the block is empty and ready
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

endmodule

bind sensor_range_calibrate_and_map_top srcm_checker u_srcm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pwm_value   (rsp_pwm_value),
   .rsp_calibrating (rsp_calibrating)
);

[verif/tb.sv]
// Testbench for sensor_range_calibrate_and_map_top: calibration of the sensor range, then
// the linear map onto [out_low, out_high], checked item by item against an internal predictor.
// Depends on srcm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
   import srcm_pkg::*;

   localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int QUIET_LIMIT = 4000;   // cycles with no item moving on either side
   localparam int HOLD_CYCLES = 400;    // long output hold in the pressure test
   localparam int DRAIN_TAIL  = 60;     // more than one mapped item's latency

   // Expected result of one sample
   typedef struct packed {
      logic [PWM_BITS-1:0] pwm_value;
      logic                calibrating;
   } pwm_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [SAMPLE_BITS-1:0]  req_sample;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [PWM_BITS-1:0]     rsp_pwm_value;
   logic                    rsp_calibrating;
   logic                    csr_wr_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]     csr_wr_data;

   // Predictor state and register copies
   logic [CNT_BITS-1:0]     cal_seen = '0;
   logic                    mapping = 1'b0;
   logic [SAMPLE_BITS-1:0]  sens_min = '1;
   logic [SAMPLE_BITS-1:0]  sens_max = '0;
   logic [CNT_BITS-1:0]     cfg_cal_samples = CAL_SAMPLES_RST;
   logic [PWM_BITS-1:0]     cfg_out_low = OUT_LOW_RST;
   logic [PWM_BITS-1:0]     cfg_out_high = OUT_HIGH_RST;

   pwm_result_type pwm_expected[$];
   int             mismatch_count = 0;
   bit             idle_enable = 1'b1;
   int             rsp_hold_request = 0;

   sensor_range_calibrate_and_map_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pwm_value   (rsp_pwm_value),
      .rsp_calibrating (rsp_calibrating),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Calibrate on the sample, or map it; updates the predictor state
   function automatic pwm_result_type predict_duty(input logic [SAMPLE_BITS-1:0] s);
      pwm_result_type         r;
      logic [SAMPLE_BITS-1:0] c;
      longint unsigned        num;
      longint unsigned        span_out;
      longint unsigned        span_in;
      r.pwm_value   = '0;
      r.calibrating = 1'b1;
      if (!mapping) begin
         if (s > sens_max) sens_max = s;
         if (s < sens_min) sens_min = s;
         if (cal_seen != '1) cal_seen = cal_seen + 1'b1;
         if (cal_seen >= cfg_cal_samples) mapping = 1'b1;
      end else begin
         r.calibrating = 1'b0;
         if (sens_max <= sens_min || cfg_out_high < cfg_out_low) begin
            r.pwm_value = cfg_out_low;
         end else begin
            // clamp into the calibrated range, then scale with truncation
            c = (s < sens_min) ? sens_min : ((s > sens_max) ? sens_max : s);
            num      = c - sens_min;
            span_in  = sens_max - sens_min;
            span_out = cfg_out_high - cfg_out_low;
            r.pwm_value = PWM_BITS'((num * span_out) / span_in + cfg_out_low);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Register write; the block must be idle
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_BITS-1:0] data);
      @(negedge clock);
      req_valid   <= 1'b0;
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CAL_SAMPLES: cfg_cal_samples = data[CNT_BITS-1:0];
         CSR_OUT_LOW:     cfg_out_low = data[PWM_BITS-1:0];
         CSR_OUT_HIGH:    cfg_out_high = data[PWM_BITS-1:0];
         default: ;
      endcase
   endtask

   // Offer one item, with an optional gap first; valid stays high after acceptance
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
      int gap;
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pwm_expected.push_back(predict_duty(s));
   endtask

   // Stop offering and wait until every result is in
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pwm_expected.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Mostly inside the calibrated range, sometimes anywhere
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      if ($urandom_range(0, 3) != 0)
         return SAMPLE_BITS'($urandom_range(int'(sens_min), int'(sens_max)));
      return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
   endfunction

   // New output limits: full, inverted, equal or random ordered
   task automatic pick_limits();
      int lo;
      int hi;
      case ($urandom_range(0, 7))
         0: begin
            lo = 0;
            hi = 65535;
         end
         1: begin
            lo = $urandom_range(1, 65535);
            hi = $urandom_range(0, lo - 1);
         end
         2: begin
            lo = $urandom_range(0, 65535);
            hi = lo;
         end
         default: begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(lo, 65535);
         end
      endcase
      write_reg(CSR_OUT_LOW, CSR_BITS'(lo));
      write_reg(CSR_OUT_HIGH, CSR_BITS'(hi));
   endtask

   // Calibration: long count, then the count lowered below what was seen
   task automatic test_calibration();
      write_reg(CSR_CAL_SAMPLES, CSR_BITS'(SAMPLE_MAX));
      write_reg(CSR_OUT_LOW, 16'h0000);
      write_reg(CSR_OUT_HIGH, 16'hFFFF);
      send_sample(10'd512);
      send_sample(10'd400);
      send_sample(10'd600);
      send_sample(10'd250);
      send_sample(10'd830);
      wait_drain();
      // zero count below seen count: this item is the last calibration one
      write_reg(CSR_CAL_SAMPLES, 16'd0);
      send_sample(10'd123);
      // range is now [123, 830]; the ends and both clamps
      send_sample(10'd123);
      send_sample(10'd830);
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd476);
      wait_drain();
   endtask

   // Limit extremes, equal and inverted limits, written while mapping
   task automatic test_limits();
      send_sample(10'd700);
      wait_drain();
      write_reg(CSR_OUT_LOW, 16'hFFFF);
      send_sample(10'd500);
      wait_drain();
      write_reg(CSR_OUT_LOW, 16'd40000);
      write_reg(CSR_OUT_HIGH, 16'd1000);
      send_sample(10'd300);
      send_sample(10'd830);
      wait_drain();
      write_reg(CSR_OUT_LOW, 16'h0000);
      write_reg(CSR_OUT_HIGH, 16'h0000);
      send_sample(10'd700);
      wait_drain();
      write_reg(CSR_OUT_LOW, 16'd1);
      write_reg(CSR_OUT_HIGH, 16'hFFFE);
      send_sample(10'd829);
      send_sample(10'd124);
      wait_drain();
   endtask

   // Random samples in bursts, limits changed between bursts
   task automatic test_random_mapping(input int n_items);
      int sent;
      int burst;
      sent = 0;
      while (sent < n_items) begin
         wait_drain();
         pick_limits();
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_CAL_SAMPLES, CSR_BITS'($urandom_range(0, SAMPLE_MAX)));
         burst = $urandom_range(10, 50);
         repeat (burst) send_sample(pick_sample());
         sent += burst;
      end
      wait_drain();
   endtask

   // Receiver holds off long enough for the block to fill and stall its input
   task automatic test_output_hold();
      wait_drain();
      rsp_hold_request = HOLD_CYCLES;
      repeat (12) send_sample(pick_sample());
      // sender pauses until everything is out
      wait_drain();
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_steady_stream();
      wait_drain();
      idle_enable = 1'b0;
      pick_limits();
      repeat (40) send_sample(pick_sample());
   endtask

   // Output stall: random bursts, or a long hold on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin : result_check
      pwm_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pwm_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result pwm_value %0d calibrating %0b",
                                      rsp_pwm_value, rsp_calibrating));
         end else begin
            want = pwm_expected.pop_front();
            if (rsp_pwm_value !== want.pwm_value)
               report_mismatch($sformatf("pwm_value %0d, predicted %0d",
                                         rsp_pwm_value, want.pwm_value));
            if (rsp_calibrating !== want.calibrating)
               report_mismatch($sformatf("calibrating %0b, predicted %0b",
                                         rsp_calibrating, want.calibrating));
         end
      end
   end

   // Watchdog: ends the run when no item moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("sensor_range_calibrate_and_map_top verification failed");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_CAL_SAMPLES;
      csr_wr_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_calibration();
      test_limits();
      test_random_mapping(520);
      test_output_hold();
      test_steady_stream();

      // let any stray result show up
      wait_drain();
      repeat (DRAIN_TAIL) @(negedge clock);
      if (mismatch_count == 0)
         $display("sensor_range_calibrate_and_map_top verification clean");
      else
         $display("sensor_range_calibrate_and_map_top verification failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/srcm_pkg.sv
hdl/srcm_front.sv
hdl/srcm_queue.sv
hdl/srcm_back.sv
hdl/sensor_range_calibrate_and_map_top.sv
hdl/srcm_checker.sv
verif/tb.sv
